### src/utf8_validating_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATING_DECODER_TOP_DEFINES_SVH
`define UTF8_VALIDATING_DECODER_TOP_DEFINES_SVH

`ifndef SYNTH
// The expression must hold at every clock edge out of reset.
`define UTF8D_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);
// The consequent must hold in the same cycle as the antecedent.
`define UTF8D_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define UTF8D_ASSERT_ALWAYS(lbl, expr, msg)
`define UTF8D_ASSERT_SAME(lbl, ante, cons, msg)
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Types, status codes and code-point bounds shared by the decoder modules.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  localparam int unsigned CP_W = 21;

  typedef logic [CP_W-1:0] cp_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEAD   = 3'd1,
    ST_BAD_CONT   = 3'd2,
    ST_OVERLONG   = 3'd3,
    ST_SURROGATE  = 3'd4,
    ST_TOO_LARGE  = 3'd5,
    ST_TRUNCATED  = 3'd6,
    ST_END_ONLY   = 3'd7
  } status_e;

  localparam cp_t MIN_LEN2      = 21'h000080;
  localparam cp_t MIN_LEN3      = 21'h000800;
  localparam cp_t MIN_LEN4      = 21'h010000;
  localparam cp_t SURR_LO       = 21'h00D800;
  localparam cp_t SURR_HI       = 21'h00DFFF;
  localparam cp_t CP_MAX        = 21'h10FFFF;
  localparam cp_t BOM_CP        = 21'h00FEFF;
  localparam logic [2:0] LEN_3  = 3'd3;

  // Decoder context carried from one byte to the next.
  typedef struct packed {
    cp_t        acc;
    logic [1:0] remaining;
    logic [2:0] seq_len;
    logic       at_start;
    logic       discarding;
  } state_t;

  typedef struct packed {
    cp_t     code_point;
    status_e status;
    logic    last;
  } result_t;

  localparam state_t STATE_RESET = '{acc: '0, remaining: 2'd0, seq_len: 3'd0,
                                     at_start: 1'b1, discarding: 1'b0};

endpackage

### src/utf8d_step.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder byte step
// Combinational next-context and result logic for one byte of a message.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::state_t  state_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output utf8d_pkg::state_t  state_o,
  output logic               have_o,
  output utf8d_pkg::result_t result_o
);

  utf8d_pkg::state_t  nxt;
  utf8d_pkg::cp_t     cp;
  utf8d_pkg::cp_t     acc_n;
  utf8d_pkg::cp_t     lowest;
  utf8d_pkg::status_e st;
  utf8d_pkg::status_e chk;
  logic [1:0]         rem_n;
  logic               have;

  // Merge the continuation payload at its place in the code point.
  always_comb begin
    rem_n = state_i.remaining - 2'd1;
    case (rem_n)
      2'd0:    acc_n = state_i.acc | {15'd0, byte_i[5:0]};
      2'd1:    acc_n = state_i.acc | {9'd0, byte_i[5:0], 6'd0};
      default: acc_n = state_i.acc | {3'd0, byte_i[5:0], 12'd0};
    endcase
  end

  always_comb begin
    case (state_i.seq_len)
      3'd2:    lowest = utf8d_pkg::MIN_LEN2;
      3'd3:    lowest = utf8d_pkg::MIN_LEN3;
      default: lowest = utf8d_pkg::MIN_LEN4;
    endcase
    if (acc_n < lowest) begin
      chk = utf8d_pkg::ST_OVERLONG;
    end else if (acc_n >= utf8d_pkg::SURR_LO && acc_n <= utf8d_pkg::SURR_HI) begin
      chk = utf8d_pkg::ST_SURROGATE;
    end else if (acc_n > utf8d_pkg::CP_MAX) begin
      chk = utf8d_pkg::ST_TOO_LARGE;
    end else begin
      chk = utf8d_pkg::ST_OK;
    end
  end

  always_comb begin
    nxt  = state_i;
    have = 1'b0;
    cp   = '0;
    st   = utf8d_pkg::ST_OK;

    if (state_i.discarding) begin
      if (last_i) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_END_ONLY;
      end
    end else if (state_i.remaining == 2'd0) begin
      if (!byte_i[7]) begin
        have         = 1'b1;
        cp           = {13'd0, byte_i};
        nxt.at_start = 1'b0;
      end else if (byte_i[7:6] != 2'b11 || byte_i[5:3] == 3'b111) begin
        // Continuation bytes and 0xF8-0xFF cannot open a sequence.
        have = 1'b1;
        st   = utf8d_pkg::ST_BAD_LEAD;
      end else if (last_i) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_TRUNCATED;
      end else if (!byte_i[5]) begin
        nxt.seq_len   = 3'd2;
        nxt.remaining = 2'd1;
        nxt.acc       = {10'd0, byte_i[4:0], 6'd0};
      end else if (!byte_i[4]) begin
        nxt.seq_len   = 3'd3;
        nxt.remaining = 2'd2;
        nxt.acc       = {5'd0, byte_i[3:0], 12'd0};
      end else begin
        nxt.seq_len   = 3'd4;
        nxt.remaining = 2'd3;
        nxt.acc       = {byte_i[2:0], 18'd0};
      end
    end else begin
      if (last_i && state_i.remaining > 2'd1) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_TRUNCATED;
      end else if (byte_i[7:6] != 2'b10) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_BAD_CONT;
      end else begin
        nxt.remaining = rem_n;
        nxt.acc       = acc_n;
        if (rem_n == 2'd0) begin
          cp = acc_n;
          st = chk;
          // A byte order mark opening the message is dropped.
          if (chk == utf8d_pkg::ST_OK && state_i.at_start &&
              state_i.seq_len == utf8d_pkg::LEN_3 && acc_n == utf8d_pkg::BOM_CP) begin
            if (last_i) begin
              have = 1'b1;
              st   = utf8d_pkg::ST_END_ONLY;
            end
          end else begin
            have = 1'b1;
          end
          nxt.at_start = 1'b0;
          nxt.acc      = '0;
          nxt.seq_len  = 3'd0;
        end
      end
    end

    if (last_i) begin
      nxt = utf8d_pkg::STATE_RESET;
    end else if (have && st != utf8d_pkg::ST_OK) begin
      nxt.discarding = 1'b1;
      nxt.acc        = '0;
      nxt.remaining  = 2'd0;
      nxt.seq_len    = 3'd0;
    end
  end

  assign state_o             = nxt;
  assign have_o              = have;
  assign result_o.code_point = (st == utf8d_pkg::ST_OK) ? cp : '0;
  assign result_o.status     = st;
  assign result_o.last       = last_i;

endmodule

### src/utf8d_out_reg.sv
// ----------------------------------------------------------------------------
// UTF-8 decoder result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  utf8d_pkg::result_t result_i,
  input  logic               ready_i,
  output logic               valid_o,
  output logic               free_o,
  output utf8d_pkg::result_t result_o
);

  logic               valid_q, valid_d;
  utf8d_pkg::result_t data_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

### src/utf8_validating_decoder_top.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder
// Decodes a byte stream into Unicode scalar values with error reporting.
// ----------------------------------------------------------------------------
// Channel  Direction  tdata                 tuser        tlast
// s_*      in         byte [7:0]            -            last byte of message
// m_*      out        code point [20:0]     status [2:0] last byte of message
//
// One byte is accepted per clock unless a stalled result fills the input
// register. A byte passes the input register, then the decode logic writes
// the context registers and, when it yields a result, the result register.
// Reset clears the context to the start of a message and empties both stages.
// A stalled result beat stalls the input stage only once that stage is full.
// ----------------------------------------------------------------------------
`include "utf8_validating_decoder_top_defines.svh"

module utf8_validating_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // [7:0] in_byte
  input  logic        s_tlast_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic [2:0]  m_tuser_o,   // [2:0] status
  output logic        m_tlast_o
);

  logic               in_valid_q, in_valid_d;
  logic [7:0]         in_byte_q;
  logic               in_last_q;
  logic               advance;
  logic               out_free;
  logic               have;
  utf8d_pkg::state_t  state_q, state_d;
  utf8d_pkg::result_t step_res;
  utf8d_pkg::result_t out_res;

  // The input stage moves on when the result register can take a beat.
  assign advance    = in_valid_q && out_free;
  assign s_tready_o = !in_valid_q || out_free;

  always_comb begin
    if (s_tvalid_i && s_tready_o) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= utf8d_pkg::STATE_RESET;
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid_i && s_tready_o) begin
      in_byte_q <= s_tdata_i;
      in_last_q <= s_tlast_i;
    end
  end

  utf8d_pkg::state_t step_state;

  utf8d_step u_step (
    .state_i  (state_q),
    .byte_i   (in_byte_q),
    .last_i   (in_last_q),
    .state_o  (step_state),
    .have_o   (have),
    .result_o (step_res)
  );

  assign state_d = advance ? step_state : state_q;

  utf8d_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance && have),
    .result_i (step_res),
    .ready_i  (m_tready_i),
    .valid_o  (m_tvalid_o),
    .free_o   (out_free),
    .result_o (out_res)
  );

  assign m_tdata_o = {3'd0, out_res.code_point};
  assign m_tuser_o = out_res.status;
  assign m_tlast_o = out_res.last;

  `UTF8D_ASSERT_ALWAYS(a_discard_clean, !state_q.discarding || (state_q.remaining == 2'd0 && state_q.acc == '0), "discard state holds a partial sequence")
  `UTF8D_ASSERT_NEXT(a_last_clears, advance && in_last_q, state_q == utf8d_pkg::STATE_RESET, "context not cleared after last byte")
  `UTF8D_ASSERT_SAME(a_err_zero_cp, m_tvalid_o && out_res.status != utf8d_pkg::ST_OK, out_res.code_point == '0, "error beat carries a code point")
  `UTF8D_ASSERT_SAME(a_ok_scalar, m_tvalid_o && out_res.status == utf8d_pkg::ST_OK, out_res.code_point <= utf8d_pkg::CP_MAX && (out_res.code_point < utf8d_pkg::SURR_LO || out_res.code_point > utf8d_pkg::SURR_HI), "ok beat is not a scalar value")
  `UTF8D_ASSERT_SAME(a_stall_backs_up, in_valid_q && m_tvalid_o && !m_tready_i, !s_tready_o && !advance, "input taken while both stages are blocked")

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// UTF-8 validating decoder testbench
// Streams messages of bytes into the decoder and predicts every code point
// and status beat it should return. Directed messages cover the corner cases;
// random messages mix well-formed text with corrupted sequences. Both stream
// sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       drain;  // hold this byte back until no result is outstanding
  } in_beat_t;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic [7:0]           s_tdata = 8'h00;
  logic                 s_tlast = 1'b0;
  logic                 m_tready = 1'b0;
  logic                 s_tready_o;
  logic                 m_tvalid_o;
  logic [23:0]          m_tdata_o;
  logic [2:0]           m_tuser_o;
  logic                 m_tlast_o;

  in_beat_t             feed_q[$];
  logic [7:0]           msg_bytes[$];
  utf8d_pkg::result_t   expected_q[$];
  int unsigned          mismatches = 0;
  int unsigned          beats_taken = 0;
  int unsigned          cyc = 0;
  logic                 calm;

  // Predicted decoder context.
  utf8d_pkg::cp_t       acc_r;
  logic [1:0]           remaining_r;
  logic [2:0]           seq_len_r;
  logic                 at_start_r;
  logic                 discarding_r;

  utf8_validating_decoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata),
    .s_tlast_i  (s_tlast),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  // A stretch in which neither side stalls.
  assign calm = (cyc >= 150) && (cyc < 300);

  function automatic void clear_context();
    acc_r        = '0;
    remaining_r  = 2'd0;
    seq_len_r    = 3'd0;
    at_start_r   = 1'b1;
    discarding_r = 1'b0;
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    msg_bytes.insert(msg_bytes.size(), b);
  endfunction

  // Advances the predicted context by one byte and queues the result it causes.
  function automatic void decode_byte(input logic [7:0] b, input logic last);
    logic               have;
    utf8d_pkg::cp_t     cp;
    utf8d_pkg::cp_t     lowest;
    utf8d_pkg::status_e st;
    logic [2:0]         len;
    utf8d_pkg::cp_t     bits;
    utf8d_pkg::result_t res;
    have = 1'b0;
    cp   = '0;
    st   = utf8d_pkg::ST_OK;
    len  = 3'd0;
    bits = '0;
    if (discarding_r) begin
      if (last) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_END_ONLY;
      end
    end else if (remaining_r == 2'd0) begin
      if (b[7] == 1'b0) begin
        have       = 1'b1;
        cp         = utf8d_pkg::cp_t'(b);
        at_start_r = 1'b0;
      end else begin
        if (b[7:5] == 3'b110) begin
          len  = 3'd2;
          bits = utf8d_pkg::cp_t'(b[4:0]);
        end else if (b[7:4] == 4'b1110) begin
          len  = 3'd3;
          bits = utf8d_pkg::cp_t'(b[3:0]);
        end else if (b[7:3] == 5'b11110) begin
          len  = 3'd4;
          bits = utf8d_pkg::cp_t'(b[2:0]);
        end
        if (len == 3'd0) begin
          have = 1'b1;
          st   = utf8d_pkg::ST_BAD_LEAD;
        end else if (last) begin
          have = 1'b1;
          st   = utf8d_pkg::ST_TRUNCATED;
        end else begin
          seq_len_r   = len;
          remaining_r = 2'(len - 3'd1);
          acc_r       = bits << (6 * (len - 3'd1));
        end
      end
    end else begin
      if (last && remaining_r > 2'd1) begin
        have = 1'b1;
        st   = utf8d_pkg::ST_TRUNCATED;
      end else if (b[7:6] != 2'b10) begin
        // The offending byte is swallowed, not retried as a lead.
        have = 1'b1;
        st   = utf8d_pkg::ST_BAD_CONT;
      end else begin
        remaining_r = remaining_r - 2'd1;
        acc_r       = acc_r | (utf8d_pkg::cp_t'(b[5:0]) << (6 * remaining_r));
        if (remaining_r == 2'd0) begin
          cp     = acc_r;
          lowest = (seq_len_r == 3'd2) ? utf8d_pkg::MIN_LEN2 :
                   (seq_len_r == 3'd3) ? utf8d_pkg::MIN_LEN3 : utf8d_pkg::MIN_LEN4;
          if (cp < lowest) st = utf8d_pkg::ST_OVERLONG;
          else if (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI)
            st = utf8d_pkg::ST_SURROGATE;
          else if (cp > utf8d_pkg::CP_MAX) st = utf8d_pkg::ST_TOO_LARGE;
          if (st == utf8d_pkg::ST_OK && at_start_r && seq_len_r == utf8d_pkg::LEN_3 &&
              cp == utf8d_pkg::BOM_CP) begin
            if (last) begin
              have = 1'b1;
              st   = utf8d_pkg::ST_END_ONLY;
            end
          end else begin
            have = 1'b1;
          end
          at_start_r = 1'b0;
          acc_r      = '0;
          seq_len_r  = 3'd0;
        end
      end
    end

    if (last) begin
      clear_context();
    end else if (have && st != utf8d_pkg::ST_OK) begin
      discarding_r = 1'b1;
      acc_r        = '0;
      remaining_r  = 2'd0;
      seq_len_r    = 3'd0;
    end

    if (have) begin
      res.code_point = (st == utf8d_pkg::ST_OK) ? cp : '0;
      res.status     = st;
      res.last       = last;
      expected_q.insert(expected_q.size(), res);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // Byte driver.
  always @(posedge clk_i) begin : drive
    in_beat_t item;
    if (rst_ni) begin
      if (s_tvalid && s_tready_o) begin
        decode_byte(s_tdata, s_tlast);
        beats_taken <= beats_taken + 1;
      end
      if (!s_tvalid || s_tready_o) begin
        if (feed_q.size() != 0 && (!feed_q[0].drain || expected_q.size() == 0) &&
            (calm || $urandom_range(99) >= 6)) begin
          item = feed_q.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= item.b;
          s_tlast  <= item.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor.
  always @(posedge clk_i) begin : watch
    utf8d_pkg::result_t want;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready) begin
        if (expected_q.size() == 0) begin
          note_mismatch($sformatf("result beat cp=%h st=%0d with nothing expected",
                                  m_tdata_o, m_tuser_o));
        end else begin
          want = expected_q.pop_front();
          if (m_tdata_o !== {3'b000, want.code_point})
            note_mismatch($sformatf("code point %h, want %h", m_tdata_o, want.code_point));
          if (m_tuser_o !== want.status)
            note_mismatch($sformatf("status %0d, want %s", m_tuser_o, want.status.name()));
          if (m_tlast_o !== want.last)
            note_mismatch($sformatf("tlast %b, want %b", m_tlast_o, want.last));
        end
      end
      m_tready <= calm || ($urandom_range(99) >= 6);
    end
  end

  task automatic send_msg(input logic drain_first);
    int       n;
    in_beat_t beat;
    n = msg_bytes.size();
    for (int i = 0; i < n; i++) begin
      beat.b     = msg_bytes[i];
      beat.last  = (i == n - 1);
      beat.drain = drain_first && (i == 0);
      feed_q.insert(feed_q.size(), beat);
    end
    msg_bytes.delete();
  endtask

  // Appends cp encoded in n bytes; n may exceed the shortest form on purpose.
  task automatic put_char(input utf8d_pkg::cp_t cp, input int n);
    case (n)
      1: add_byte(cp[7:0]);
      2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic random_msg(input logic drain_first);
    int unsigned    nch;
    int unsigned    kind;
    int unsigned    n;
    logic           clean;
    utf8d_pkg::cp_t cp;
    nch   = $urandom_range(6, 1);
    clean = 1'($urandom_range(1));
    if ($urandom_range(9) == 0) put_char(utf8d_pkg::BOM_CP, 3);
    for (int unsigned i = 0; i < nch; i++) begin
      kind = clean ? $urandom_range(87) : $urandom_range(99);
      if (kind < 30) begin
        put_char(utf8d_pkg::cp_t'($urandom_range(127)), 1);
      end else if (kind < 50) begin
        put_char(utf8d_pkg::cp_t'($urandom_range(32'h7FF, 32'h80)), 2);
      end else if (kind < 65) begin
        cp = utf8d_pkg::cp_t'($urandom_range(32'hFFFF, 32'h800));
        if (cp >= utf8d_pkg::SURR_LO && cp <= utf8d_pkg::SURR_HI) cp = cp ^ 21'h002000;
        put_char(cp, 3);
      end else if (kind < 82) begin
        put_char(utf8d_pkg::cp_t'($urandom_range(32'h10FFFF, 32'h10000)), 4);
      end else if (kind < 88) begin
        // A U+FEFF that does not open the message is an ordinary character.
        put_char(utf8d_pkg::BOM_CP, 3);
      end else if (kind < 90) begin
        n  = $urandom_range(4, 2);
        cp = utf8d_pkg::cp_t'($urandom_range((n == 2) ? 32'h7F : (n == 3) ? 32'h7FF
                                                                           : 32'hFFFF));
        put_char(cp, n);
      end else if (kind < 92) begin
        put_char(utf8d_pkg::cp_t'($urandom_range(32'hDFFF, 32'hD800)), 3);
      end else if (kind < 94) begin
        put_char(utf8d_pkg::cp_t'($urandom_range(32'h1FFFFF, 32'h110000)), 4);
      end else if (kind < 96) begin
        add_byte(8'($urandom_range(255)));
      end else if (kind < 98) begin
        // Cut a sequence short so the next byte or the end of message hits it.
        put_char(utf8d_pkg::cp_t'($urandom_range(32'h10FFFF, 32'h10000)), 4);
        n = $urandom_range(3, 1);
        repeat (n) void'(msg_bytes.pop_back());
      end else begin
        add_byte($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                   : 8'($urandom_range(8'hFF, 8'hF8)));
      end
    end
    send_msg(drain_first);
  endtask

  initial begin
    int unsigned total;
    int unsigned directed;
    int unsigned nmsg;
    clear_context();

    msg_bytes = '{8'h00, 8'h7F};               send_msg(1'b0);
    msg_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41}; send_msg(1'b0);  // leading BOM dropped
    msg_bytes = '{8'hEF, 8'hBB, 8'hBF};        send_msg(1'b0);  // BOM alone
    msg_bytes = '{8'h80, 8'h41, 8'hFF};        send_msg(1'b0);  // bad lead, discard
    msg_bytes = '{8'hC2};                      send_msg(1'b0);  // lead as last byte
    msg_bytes = '{8'hE0, 8'h80};               send_msg(1'b0);  // two still owed
    msg_bytes = '{8'hC0, 8'h80};               send_msg(1'b0);  // overlong
    msg_bytes = '{8'hED, 8'hA0, 8'h80};        send_msg(1'b0);  // surrogate
    msg_bytes = '{8'hF7, 8'hBF, 8'hBF, 8'hBF}; send_msg(1'b0);  // above U+10FFFF
    msg_bytes = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_msg(1'b0);  // U+10FFFF
    msg_bytes = '{8'hC2, 8'h41, 8'h42};        send_msg(1'b0);  // bad continuation
    directed = feed_q.size();

    nmsg = 0;
    while (feed_q.size() < directed + 400) begin
      random_msg(nmsg == 0 || nmsg == 60);
      nmsg++;
    end
    total = feed_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (beats_taken != total) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/utf8d_pkg.sv
src/utf8d_step.sv
src/utf8d_out_reg.sv
src/utf8_validating_decoder_top.sv
test/tb_top.sv
